// File: src/keyed_record_table_assert.svh
// assertion macros for the keyed record table
// expects clk_i and rst_ni in the including scope
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// property checked at every clock edge outside reset
`define KRT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define KRT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/krt_pkg.sv
// shared types and constants for the keyed record table
// no dependencies
`timescale 1ns / 1ps

package krt_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int WORD_W = 64;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 4;
  localparam int DATA_W = KEY_W + 2 * WORD_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE = 3'd0,
    ACT_READ   = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_LIST   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_CREATED   = 4'd0,
    ST_FULL      = 4'd1,
    ST_DUPLICATE = 4'd2,
    ST_FOUND     = 4'd3,
    ST_NOTFOUND  = 4'd4,
    ST_UPDATED   = 4'd5,
    ST_DELETED   = 4'd6,
    ST_LISTED    = 4'd7,
    ST_EMPTY     = 4'd8
  } status_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [WORD_W-1:0]       name;
    logic [WORD_W-1:0]       email;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    req_load;
    logic    find_load;
    logic    append;
    logic    upd_wr;
    logic    shift;
    logic    dec_count;
    logic    ptr_clr;
    logic    ptr_set;
    logic    ptr_inc;
    logic    rd_en;
    logic    rd_idx;
    logic    wr_move;
    logic    out_load;
    logic    out_src_mem;
    status_e out_status;
    logic    out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             hit;
    logic             full;
    logic             empty;
    logic             ptr_lt_cnt;
    logic             ptr_last;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

// File: src/keyed_record_table.sv
// keyed record table: up to 64 records of a signed 32-bit key and two 64-bit payload words,
// kept in insertion order. Create, read, update, delete and list operations arrive one per
// input transaction; each causes one result, except list, which gives one result per record
// with tlast on the final one, and an unused action code, which gives none. One transaction
// is worked at a time: s_axis_tready is high only while the controller is idle. A delete
// moves the later records down one place at a time through the record memory with registered
// read, with a read and a write for each record. A result still waiting on m_axis_tready
// holds back the next result load until it is taken. Keys are compared against all 64 key
// cells at once when a transaction is accepted. No clearing pass is needed after reset.
// depends on krt_pkg, krt_ctrl, krt_dp and keyed_record_table_assert.svh
`timescale 1ns / 1ps
`include "keyed_record_table_assert.svh"

module keyed_record_table import krt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // key[31:0], name_word[95:32], email_word[159:96]
  input  logic [ACT_W-1:0]  s_axis_tuser,  // action[2:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // key_out[31:0], name_out[95:32], email_out[159:96]
  output logic [STAT_W-1:0] m_axis_tuser,  // status[3:0]
  output logic              m_axis_tlast
);

  cmd_t   cmd;
  sts_t   sts;
  entry_t out_entry;
  logic   in_accept;
  logic   out_mid;

  krt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  krt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_action_i  (s_axis_tuser),
    .in_key_i     (s_axis_tdata[KEY_W-1:0]),
    .in_name_i    (s_axis_tdata[KEY_W+WORD_W-1:KEY_W]),
    .in_email_i   (s_axis_tdata[DATA_W-1:KEY_W+WORD_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_entry_o  (out_entry),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_entry.email, out_entry.name, out_entry.key};

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_mid   = m_axis_tvalid && !m_axis_tlast;

  `KRT_ASSERT(a_count_bound, sts.count <= CNT_W'(DEPTH), "record count beyond depth")
  `KRT_ASSERT(a_append_room, cmd.append |-> !sts.full, "append into a full table")
  `KRT_ASSERT(a_mid_list, out_mid |-> (m_axis_tuser == ST_LISTED), "non-final result not listed")
  `KRT_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready, "accepted while busy")

endmodule

// File: src/krt_ctrl.sv
// controller state machine for the keyed record table
// depends on krt_pkg
`timescale 1ns / 1ps

module krt_ctrl import krt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIND = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_RESP = 4'd3;
  localparam logic [3:0] S_DRD  = 4'd4;
  localparam logic [3:0] S_DWR  = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;
  localparam logic [3:0] S_LRD  = 4'd7;
  localparam logic [3:0] S_LOUT = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = ST_CREATED;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        cmd_o.find_load = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        case (sts_i.action)
          ACT_CREATE: begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else if (sts_i.hit) begin
                cmd_o.out_status = ST_DUPLICATE;
              end else begin
                cmd_o.append     = 1'b1;
                cmd_o.out_status = ST_CREATED;
              end
              state_d = S_IDLE;
            end
          end
          ACT_READ: begin
            if (sts_i.hit) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_idx = 1'b1;
              state_d = S_RESP;
            end else if (sts_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = ST_NOTFOUND;
              state_d = S_IDLE;
            end
          end
          ACT_UPDATE: begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.hit) begin
                cmd_o.upd_wr     = 1'b1;
                cmd_o.out_status = ST_UPDATED;
              end else begin
                cmd_o.out_status = ST_NOTFOUND;
              end
              state_d = S_IDLE;
            end
          end
          ACT_DELETE: begin
            if (sts_i.hit) begin
              cmd_o.shift   = 1'b1;
              cmd_o.ptr_set = 1'b1;
              state_d = S_DRD;
            end else if (sts_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = ST_NOTFOUND;
              state_d = S_IDLE;
            end
          end
          ACT_LIST: begin
            if (!sts_i.empty) begin
              cmd_o.ptr_clr = 1'b1;
              state_d = S_LRD;
            end else if (sts_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = ST_EMPTY;
              state_d = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RESP: begin
        cmd_o.rd_idx = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_src_mem = 1'b1;
          cmd_o.out_last    = 1'b1;
          cmd_o.out_status  = ST_FOUND;
          state_d = S_IDLE;
        end
      end
      S_DRD: begin
        if (sts_i.ptr_lt_cnt) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_DWR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DWR: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d = S_DRD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.dec_count  = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = ST_DELETED;
          state_d = S_IDLE;
        end
      end
      S_LRD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_LOUT;
      end
      S_LOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_src_mem = 1'b1;
          cmd_o.out_last    = sts_i.ptr_last;
          cmd_o.out_status  = ST_LISTED;
          cmd_o.ptr_inc     = 1'b1;
          state_d = sts_i.ptr_last ? S_IDLE : S_LRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/krt_dp.sv
// datapath: key cells with parallel compare, record memory, count, output register
// depends on krt_pkg
`timescale 1ns / 1ps

module krt_dp import krt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ACT_W-1:0]        in_action_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  input  logic [WORD_W-1:0]       in_name_i,
  input  logic [WORD_W-1:0]       in_email_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [STAT_W-1:0]       out_status_o,
  output entry_t                  out_entry_o,
  output logic                    out_last_o
);

  logic signed [KEY_W-1:0] cells_q [DEPTH];
  entry_t                  mem [DEPTH];
  entry_t                  rd_q;
  entry_t                  req_q;
  logic [ACT_W-1:0]        act_q;
  logic [DEPTH-1:0]        match_q, match_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    hit_q;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        ptr_q;
  logic [CNT_W-1:0]        ptr_nxt;
  logic [CNT_W-1:0]        ptr_prev;
  logic                    out_valid_q;
  logic [STAT_W-1:0]       out_status_q;
  entry_t                  out_q;
  logic                    out_last_q;
  logic                    out_free;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  entry_t                  wr_data;
  logic [IDX_W-1:0]        rd_addr;

  // parallel key compare against live cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (cells_q[i] == in_key_i) && (CNT_W'(i) < count_q);
    end
  end

  always_comb begin
    idx_d = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        idx_d = IDX_W'(i);
      end
    end
  end

  assign ptr_nxt  = ptr_q + CNT_W'(1);
  assign ptr_prev = ptr_q - CNT_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      act_q       <= in_action_i;
      req_q.key   <= in_key_i;
      req_q.name  <= in_name_i;
      req_q.email <= in_email_i;
      match_q     <= match_d;
    end
    if (cmd_i.find_load) begin
      idx_q <= idx_d;
      hit_q <= |match_q;
    end
    if (cmd_i.append) begin
      cells_q[count_q[IDX_W-1:0]] <= req_q.key;
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDX_W'(i) >= idx_q) begin
          cells_q[i] <= cells_q[i+1];
        end
      end
    end
  end

  // record memory, one write and one registered read per cycle
  always_comb begin
    wr_en   = cmd_i.append || cmd_i.upd_wr || cmd_i.wr_move;
    wr_addr = idx_q;
    wr_data = req_q;
    if (cmd_i.append) begin
      wr_addr = count_q[IDX_W-1:0];
    end else if (cmd_i.wr_move) begin
      wr_addr = ptr_prev[IDX_W-1:0];
      wr_data = rd_q;
    end
  end

  assign rd_addr = cmd_i.rd_idx ? idx_q : ptr_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_set) begin
        ptr_q <= CNT_W'(idx_q) + CNT_W'(1);
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_nxt;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
      if (cmd_i.out_src_mem) begin
        out_q <= rd_q;
      end else begin
        out_q.key   <= req_q.key;
        out_q.name  <= '0;
        out_q.email <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_entry_o  = out_q;
  assign out_last_o   = out_last_q;

  always_comb begin
    sts_o.action     = act_q;
    sts_o.hit        = hit_q;
    sts_o.full       = (count_q >= CNT_W'(DEPTH));
    sts_o.empty      = (count_q == '0);
    sts_o.ptr_lt_cnt = (ptr_q < count_q);
    sts_o.ptr_last   = (ptr_nxt == count_q);
    sts_o.out_free   = out_free;
    sts_o.count      = count_q;
  end

endmodule
